// File: src/ps2_scan_code_key_state_map_macros.svh
// assertion macros for the scan code key state map
`ifndef PS2_SCAN_CODE_KEY_STATE_MAP_MACROS_SVH
`define PS2_SCAN_CODE_KEY_STATE_MAP_MACROS_SVH

`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define PS2SC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property on every clock edge, reset included
`define PS2SC_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PS2SC_ASSERT(name, clk, rst, prop, msg)
`define PS2SC_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// File: src/ps2sc_pkg.sv
// shared constants and types for the scan code key state map
package ps2sc_pkg;

   // key map size
   localparam int MAP_BYTES = 32;
   localparam int MAP_BITS  = MAP_BYTES * 8;
   localparam int MAP_IDX_W = $clog2(MAP_BITS);

   // dump of the map after each key event
   localparam int DUMP_LEN   = 32;
   localparam int DUMP_IDX_W = 5;
   localparam logic [DUMP_IDX_W-1:0] DUMP_LAST = DUMP_IDX_W'(DUMP_LEN - 1);

   // key bit index, wide enough for an extended code plus offset
   localparam int BIT_IDX_W = 9;

   // scan code bytes with special meaning
   localparam logic [7:0] CODE_NONE      = 8'h00;
   localparam logic [7:0] CODE_BREAK     = 8'hF0;
   localparam logic [7:0] CODE_EXTENDED  = 8'hE0;
   localparam logic [7:0] CODE_PAUSE     = 8'hE1;
   localparam logic [7:0] CODE_PAUSE_END = 8'h77;

   localparam logic [BIT_IDX_W-1:0] PAUSE_BIT  = 9'd225;
   localparam logic [BIT_IDX_W-1:0] EXT_OFFSET = 9'd128;

   localparam logic [7:0] LOW_MASK  = 8'h0F;
   localparam logic [7:0] HIGH_MASK = 8'hF0;

   // queue depth between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // pending prefix bytes
   typedef struct packed {
      logic pau;
      logic ext;
      logic brk;
   } prefix_flags_type;

   // one key event for the back end
   typedef struct packed {
      logic [BIT_IDX_W-1:0] bit_idx;
      logic                 set_key;
   } key_event_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: src/ps2_scan_code_key_state_map.sv
// Scan code key state map top level.
// Prefix, zero and skipped words are taken one per cycle while the event queue has room.
// A key event word passes through the event queue and the dump sequencer before its dump starts; the dump is 32 words,
// one per cycle while the receiver is ready, and the dump sequencer takes no new event until that dump has ended.
// Synchronous reset clears prefix flags, queue, dump state and the whole key map.
`include "ps2_scan_code_key_state_map_macros.svh"

module ps2_scan_code_key_state_map (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_scan_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [4:0] rsp_map_byte_index,
   output logic [3:0] rsp_low_part,
   output logic [7:0] rsp_high_part,
   output logic       rsp_last
);
   import ps2sc_pkg::*;

   queue_status_type q_status;
   key_event_type    push_data;
   key_event_type    pop_data;
   logic             push;
   logic             pop;

   // prefix tracking and classification
   ps2sc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_scan_code (req_scan_code),
      .q_status      (q_status),
      .ev_push       (push),
      .ev_data       (push_data)
   );

   // event queue
   ps2sc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   // map update and dump
   ps2sc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .ev_data            (pop_data),
      .ev_pop             (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_map_byte_index (rsp_map_byte_index),
      .rsp_low_part       (rsp_low_part),
      .rsp_high_part      (rsp_high_part),
      .rsp_last           (rsp_last)
   );

   // consistency checks
   `PS2SC_ASSERT(a_no_push_full, clock, reset, push |-> !q_status.full, "push into full queue")
   `PS2SC_ASSERT(a_no_pop_empty, clock, reset, pop |-> !q_status.empty, "pop from empty queue")
   `PS2SC_ASSERT(a_last_index, clock, reset, (rsp_valid && rsp_last) |-> (rsp_map_byte_index == DUMP_LAST), "last flag off the final byte")
   `PS2SC_ASSERT(a_dump_order, clock, reset, (rsp_valid && rsp_ready && !rsp_last) |=> (rsp_map_byte_index == $past(rsp_map_byte_index) + 5'd1 || !rsp_valid), "dump bytes out of order")
   `PS2SC_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "result valid right after reset")

endmodule

// File: src/ps2sc_front.sv
// front end: takes scan code words, tracks prefixes, emits key events
module ps2sc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_scan_code,
   input  ps2sc_pkg::queue_status_type q_status,
   output logic                      ev_push,
   output ps2sc_pkg::key_event_type  ev_data
);
   import ps2sc_pkg::*;

   prefix_flags_type flags_ff, flags_in;
   logic accept;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   // classify the accepted word
   always_comb begin
      logic hit;
      logic [BIT_IDX_W-1:0] plain_idx;
      logic [BIT_IDX_W-1:0] ext_idx;
      hit       = 1'b0;
      plain_idx = BIT_IDX_W'(req_scan_code);
      ext_idx   = plain_idx + EXT_OFFSET;
      flags_in  = flags_ff;
      ev_data   = '0;
      if (accept && req_scan_code != CODE_NONE) begin
         priority if (req_scan_code == CODE_BREAK) begin
            flags_in.brk = 1'b1;
         end else if (req_scan_code == CODE_EXTENDED) begin
            flags_in.ext = 1'b1;
         end else if (req_scan_code == CODE_PAUSE) begin
            flags_in.pau = 1'b1;
         end else begin
            priority if (flags_ff.brk) begin
               priority if (flags_ff.pau) begin
                  hit             = (req_scan_code == CODE_PAUSE_END);
                  ev_data.bit_idx = PAUSE_BIT;
               end else if (flags_ff.ext) begin
                  hit             = 1'b1;
                  ev_data.bit_idx = ext_idx;
               end else begin
                  hit             = 1'b1;
                  ev_data.bit_idx = plain_idx;
               end
               ev_data.set_key = 1'b0;
            end else if (flags_ff.ext) begin
               hit             = 1'b1;
               ev_data.bit_idx = ext_idx;
               ev_data.set_key = 1'b1;
            end else if (flags_ff.pau) begin
               hit             = (req_scan_code == CODE_PAUSE_END);
               ev_data.bit_idx = PAUSE_BIT;
               ev_data.set_key = 1'b1;
            end else begin
               hit             = 1'b1;
               ev_data.bit_idx = plain_idx;
               ev_data.set_key = 1'b1;
            end
            // a completed event clears the prefixes
            if (hit) begin
               flags_in = '0;
            end
         end
      end
      ev_push = hit;
   end

   // prefix flag register
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

endmodule

// File: src/ps2sc_fifo.sv
// short event queue between front and back end
module ps2sc_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  ps2sc_pkg::key_event_type    push_data,
   input  logic                        pop,
   output ps2sc_pkg::key_event_type    pop_data,
   output ps2sc_pkg::queue_status_type status
);
   import ps2sc_pkg::*;

   key_event_type          mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/ps2sc_back.sv
// back end: applies key events to the map and dumps it word by word
module ps2sc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  ps2sc_pkg::queue_status_type q_status,
   input  ps2sc_pkg::key_event_type    ev_data,
   output logic                        ev_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [4:0]                  rsp_map_byte_index,
   output logic [3:0]                  rsp_low_part,
   output logic [7:0]                  rsp_high_part,
   output logic                        rsp_last
);
   import ps2sc_pkg::*;

   logic [MAP_BITS-1:0]   key_map_ff, key_map_in;
   logic                  dump_active_ff, dump_active_in;
   logic [DUMP_IDX_W-1:0] cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [4:0]            rsp_index_ff, rsp_index_in;
   logic [3:0]            rsp_low_ff, rsp_low_in;
   logic [7:0]            rsp_high_ff, rsp_high_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  load;
   logic [7:0]            map_byte;

   assign load   = !rsp_valid_ff || rsp_ready;
   assign ev_pop = !dump_active_ff && !q_status.empty;

   // byte of the map under the dump counter
   assign map_byte = key_map_ff[MAP_IDX_W'({cnt_ff, 3'b000}) +: 8];

   // map update and dump sequencing
   always_comb begin
      key_map_in     = key_map_ff;
      dump_active_in = dump_active_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_low_in     = rsp_low_ff;
      rsp_high_in    = rsp_high_ff;
      rsp_last_in    = rsp_last_ff;
      if (ev_pop) begin
         // indices past the map change nothing
         if (ev_data.bit_idx < BIT_IDX_W'(MAP_BITS)) begin
            key_map_in[ev_data.bit_idx[MAP_IDX_W-1:0]] = ev_data.set_key;
         end
         dump_active_in = 1'b1;
         cnt_in         = '0;
      end
      if (load) begin
         if (dump_active_ff) begin
            rsp_valid_in = 1'b1;
            rsp_index_in = cnt_ff;
            rsp_low_in   = 4'(map_byte & LOW_MASK);
            rsp_high_in  = map_byte & HIGH_MASK;
            rsp_last_in  = (cnt_ff == DUMP_LAST);
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DUMP_LAST) begin
               dump_active_in = 1'b0;
            end
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   // control state and key map
   always_ff @(posedge clock) begin
      if (reset) begin
         key_map_ff     <= '0;
         dump_active_ff <= 1'b0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         key_map_ff     <= key_map_in;
         dump_active_ff <= dump_active_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_low_ff   <= rsp_low_in;
      rsp_high_ff  <= rsp_high_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_map_byte_index = rsp_index_ff;
   assign rsp_low_part       = rsp_low_ff;
   assign rsp_high_part      = rsp_high_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

// File: tb/ps2_scan_code_key_state_map_test.sv
// testbench for the scan code key state map: random and directed scan code words
`timescale 1ns / 100ps

import ps2sc_pkg::*;

// one dumped map word as the block should present it
typedef struct packed {
   logic [DUMP_IDX_W-1:0] index;
   logic [3:0]            low;
   logic [7:0]            high;
   logic                  last;
} map_word_type;

// tracks the key map and the dump words still owed by the block
class key_map_scoreboard;
   prefix_flags_type flags;
   logic [7:0]       key_map [MAP_BYTES];
   map_word_type     dump_words [$];
   int               mismatches;
   int               key_events;
   int               words_checked;

   function new();
      flags = '0;
      foreach (key_map[i]) key_map[i] = '0;
      mismatches = 0;
      key_events = 0;
      words_checked = 0;
   endfunction

   // indices past the map are dropped
   function void put_key(int bit_pos, logic on);
      if (bit_pos < MAP_BITS) key_map[bit_pos / 8][bit_pos % 8] = on;
   endfunction

   // update flags and map for an accepted scan code, queue the dump if an event ends
   function void apply_code(logic [7:0] code);
      logic         ended;
      logic [7:0]   b;
      map_word_type w;
      ended = 1'b1;
      if (code == CODE_NONE) return;
      if (code == CODE_BREAK) begin
         flags.brk = 1'b1;
         return;
      end
      if (code == CODE_EXTENDED) begin
         flags.ext = 1'b1;
         return;
      end
      if (code == CODE_PAUSE) begin
         flags.pau = 1'b1;
         return;
      end
      // break takes priority, then extended, then pause
      if (flags.brk) begin
         if (flags.pau) begin
            if (code == CODE_PAUSE_END) put_key(int'(PAUSE_BIT), 1'b0);
            else ended = 1'b0;
         end else if (flags.ext) begin
            put_key(int'(code) + int'(EXT_OFFSET), 1'b0);
         end else begin
            put_key(int'(code), 1'b0);
         end
      end else if (flags.ext) begin
         put_key(int'(code) + int'(EXT_OFFSET), 1'b1);
      end else if (flags.pau) begin
         if (code == CODE_PAUSE_END) put_key(int'(PAUSE_BIT), 1'b1);
         else ended = 1'b0;
      end else begin
         put_key(int'(code), 1'b1);
      end
      // skipped codes under pause keep the flags
      if (!ended) return;
      flags = '0;
      key_events++;
      for (int i = 0; i < DUMP_LEN; i++) begin
         b = (i < MAP_BYTES) ? key_map[i] : 8'h00;
         w.index = DUMP_IDX_W'(i);
         w.low   = 4'(b & LOW_MASK);
         w.high  = b & HIGH_MASK;
         w.last  = (w.index == DUMP_LAST);
         dump_words.push_back(w);
      end
   endfunction

   // compare one received map word with the oldest one owed
   function void check_word(logic [DUMP_IDX_W-1:0] index, logic [3:0] low,
                            logic [7:0] high, logic last);
      map_word_type want;
      if (dump_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected map word: index %0d low %h high %h last %b",
                     index, low, high, last);
         return;
      end
      want = dump_words.pop_front();
      words_checked++;
      if (index !== want.index || low !== want.low || high !== want.high ||
          last !== want.last) begin
         mismatches++;
         if (mismatches <= 10)
            $display("map word mismatch: expected index %0d low %h high %h last %b, got index %0d low %h high %h last %b",
                     want.index, want.low, want.high, want.last, index, low, high, last);
      end
   endfunction

   function int pending();
      return dump_words.size();
   endfunction
endclass

module ps2_scan_code_key_state_map_test;

   localparam int ITEM_TARGET = 460;
   localparam int CALM_ITEMS  = 60;
   localparam int DRAIN_WAIT  = 40;
   localparam int CYCLE_LIMIT = 600000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_scan_code = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b1;
   logic [4:0] rsp_map_byte_index;
   logic [3:0] rsp_low_part;
   logic [7:0] rsp_high_part;
   logic       rsp_last;

   key_map_scoreboard sb;
   logic [7:0]        code_run [$];
   bit                idling = 1'b0;
   int                codes_sent = 0;
   int                cycle_count = 0;

   ps2_scan_code_key_state_map dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_scan_code      (req_scan_code),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_map_byte_index (rsp_map_byte_index),
      .rsp_low_part       (rsp_low_part),
      .rsp_high_part      (rsp_high_part),
      .rsp_last           (rsp_last)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watch both channels and check results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.apply_code(req_scan_code);
         if (rsp_valid && rsp_ready)
            sb.check_word(rsp_map_byte_index, rsp_low_part, rsp_high_part, rsp_last);
      end
   end

   // give up on a hung run
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles with %0d map words pending",
                  cycle_count, sb.pending());
         $display("simulation failed");
         $finish;
      end
   end

   // receiver stalls in short bursts while idling is on
   initial begin
      forever begin
         @(posedge clock);
         if (idling && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // nonzero non-prefix scan code
   function automatic logic [7:0] any_code();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (c == CODE_BREAK || c == CODE_EXTENDED || c == CODE_PAUSE);
      return c;
   endfunction

   // mostly a small pool so keys get released as well as pressed
   function automatic logic [7:0] key_code();
      if ($urandom_range(0, 2) != 0) return 8'($urandom_range(8'h10, 8'h27));
      return any_code();
   endfunction

   // send one word, with an optional gap in front
   task send_code(input logic [7:0] code);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_scan_code <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (code != CODE_NONE) codes_sent++;
   endtask

   task play_run();
      foreach (code_run[i]) send_code(code_run[i]);
      code_run.delete();
   endtask

   // hold off the sender until every owed map word has come
   task settle();
      req_valid <= 1'b0;
      do @(posedge clock);
      while (sb.pending() != 0);
   endtask

   initial begin
      logic [7:0] code;
      logic [7:0] pre;
      int         kind;

      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, all prefixes, pause sequence, dropped index, zero words
      idling = 1'b1;
      code_run = '{CODE_NONE, 8'h01, 8'hFF, CODE_BREAK, 8'h01,
                   CODE_EXTENDED, 8'h7F, CODE_EXTENDED, 8'h80,
                   CODE_EXTENDED, CODE_BREAK, 8'h7F,
                   CODE_PAUSE, 8'h14, CODE_PAUSE_END,
                   CODE_PAUSE, CODE_BREAK, 8'h14, CODE_BREAK, CODE_PAUSE_END,
                   CODE_BREAK, CODE_NONE, CODE_BREAK, 8'hFF,
                   CODE_PAUSE, CODE_EXTENDED, 8'h12};
      play_run();
      settle();

      // random key sequences with some noise
      while (codes_sent < ITEM_TARGET) begin
         if (codes_sent >= ITEM_TARGET - CALM_ITEMS) idling = 1'b0;
         else if ($urandom_range(0, 29) == 0) idling = !idling;
         if ($urandom_range(0, 49) == 0) settle();
         kind = $urandom_range(0, 19);
         if (kind <= 7) begin
            // plain make or break
            code = key_code();
            if ($urandom_range(0, 1) != 0) code_run = '{code};
            else code_run = '{CODE_BREAK, code};
         end else if (kind <= 11) begin
            // extended make or break, either prefix order
            code = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h69, 8'h7D))
                                               : any_code();
            case ($urandom_range(0, 2))
               0: code_run = '{CODE_EXTENDED, code};
               1: code_run = '{CODE_EXTENDED, CODE_BREAK, code};
               default: code_run = '{CODE_BREAK, CODE_EXTENDED, code};
            endcase
         end else if (kind <= 13) begin
            // pause key press or release
            code = ($urandom_range(0, 4) != 0) ? 8'h14 : any_code();
            if ($urandom_range(0, 1) != 0)
               code_run = '{CODE_PAUSE, code, CODE_PAUSE_END};
            else
               code_run = '{CODE_PAUSE, CODE_BREAK, code, CODE_BREAK, CODE_PAUSE_END};
         end else if (kind <= 15) begin
            // repeated and mixed prefixes
            code = key_code();
            case ($urandom_range(0, 2))
               0: code_run = '{CODE_BREAK, CODE_BREAK, code};
               1: code_run = '{CODE_EXTENDED, CODE_EXTENDED, CODE_BREAK, code};
               default: code_run = '{CODE_PAUSE, CODE_EXTENDED, code};
            endcase
         end else if (kind <= 17) begin
            // a prefix followed by anything
            case ($urandom_range(0, 2))
               0: pre = CODE_BREAK;
               1: pre = CODE_EXTENDED;
               default: pre = CODE_PAUSE;
            endcase
            code_run = '{pre, 8'($urandom_range(0, 255))};
         end else begin
            // raw noise, zero words included
            repeat ($urandom_range(1, 3)) begin
               code = ($urandom_range(0, 5) == 0) ? CODE_NONE : 8'($urandom_range(0, 255));
               code_run.push_back(code);
            end
         end
         play_run();
      end

      // drain and let any stray words show up
      settle();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("sent %0d nonzero scan code words, %0d key events, %0d map words checked",
               codes_sent, sb.key_events, sb.words_checked);
      $display("%0d map words wrong or unexpected, %0d never arrived",
               sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: ps2_scan_code_key_state_map.f
+incdir+src
src/ps2sc_pkg.sv
src/ps2sc_front.sv
src/ps2sc_fifo.sv
src/ps2sc_back.sv
src/ps2_scan_code_key_state_map.sv
tb/ps2_scan_code_key_state_map_test.sv
